FILE: rtl/core/mdc_pkg.sv
`timescale 1ns / 1ps
package mdc_pkg;

	localparam int SIZE_W    = 3;
	localparam int OUT_W     = 64;
	localparam int FRAC_BITS = 8;
	localparam int OUT_FRAC  = 16;
	localparam int NUM_M2    = 6;
	localparam int NUM_M3    = 4;
	localparam int MIDX_W    = 3;

	typedef enum logic [1:0] {OP_NOP, OP_LDA, OP_MAC} op_t;
	typedef enum logic [1:0] {SRC_A, SRC_M2, SRC_M3, SRC_ONE} src_t;
	typedef enum logic [1:0] {DST_M2, DST_M3, DST_FINAL} dst_t;

	typedef struct packed {
		op_t               op;
		src_t              src;
		logic [MIDX_W-1:0] midx;
		logic              neg;
		logic              last;
		dst_t              dst;
		logic [MIDX_W-1:0] didx;
	} uop_t;

	typedef struct packed {
		logic [1:0] a;
		logic [1:0] b;
	} pair_t;

	typedef struct packed {
		logic [1:0] a;
		logic [1:0] b;
		logic [1:0] c;
	} trio_t;

	function automatic pair_t pair_cols(input logic [2:0] p);
		pair_t r;
		case (p)
			3'd0: r = '{a: 2'd0, b: 2'd1};
			3'd1: r = '{a: 2'd0, b: 2'd2};
			3'd2: r = '{a: 2'd0, b: 2'd3};
			3'd3: r = '{a: 2'd1, b: 2'd2};
			3'd4: r = '{a: 2'd1, b: 2'd3};
			default: r = '{a: 2'd2, b: 2'd3};
		endcase
		return r;
	endfunction

	function automatic logic [2:0] pair_idx(input logic [1:0] a, input logic [1:0] b);
		logic [2:0] r;
		case ({a, b})
			4'b0001: r = 3'd0;
			4'b0010: r = 3'd1;
			4'b0011: r = 3'd2;
			4'b0110: r = 3'd3;
			4'b0111: r = 3'd4;
			4'b1011: r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic trio_t other_cols(input logic [1:0] j);
		trio_t r;
		case (j)
			2'd0: r = '{a: 2'd1, b: 2'd2, c: 2'd3};
			2'd1: r = '{a: 2'd0, b: 2'd2, c: 2'd3};
			2'd2: r = '{a: 2'd0, b: 2'd1, c: 2'd3};
			default: r = '{a: 2'd0, b: 2'd1, c: 2'd2};
		endcase
		return r;
	endfunction

	function automatic logic [3:0] elem_addr(input logic [1:0] r, input logic [1:0] c,
			input logic [2:0] n);
		logic [4:0] t;
		t = 5'(r) * 5'(n) + 5'(c);
		return t[3:0];
	endfunction

endpackage

FILE: rtl/core/matrix_determinant_cofactor.sv
`timescale 1ns / 1ps
// Determinant of a square matrix of signed Q8.8 elements by cofactor expansion
// along the first row, result in signed Q47.16 with saturation flag.
// Input: drive element_value with start high; the item is taken at a rising
// edge where start is high and busy is low. Elements come in row-major order.
// Output: determinant, saturated and size_error are valid for the single
// cycle in which done is high; the receiver cannot stall, so it must take them.
// Configuration: cfg_we with cfg_wdata sets matrix_size and restarts the
// matrix; write only while the block is idle.
// Elements load back to back while busy is low. After the last element the
// sequencer streams reads from the two-port element memory into one multiply-
// accumulate unit, one operation per cycle except in the gap states between
// levels; the final sum then passes the read-data, product, result and output
// registers. busy stays high from the last element until the result is loaded,
// so a new matrix starts in the cycle done is high. A size of zero answers
// each item in the next cycle with size_error set and determinant zero.
// Reset clears the element count and sets matrix_size to one; the element
// memory is not cleared and needs no clearing pass.
module matrix_determinant_cofactor import mdc_pkg::*; #(
	parameter int MAX_ORDER  = 4,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [15:0]      element_value,
	input  logic                    cfg_we,
	input  logic [SIZE_W-1:0]       cfg_wdata,
	output logic signed [OUT_W-1:0] determinant,
	output logic                    saturated,
	output logic                    size_error,
	output logic                    done
);

	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [SIZE_W-1:0] size_q;
	logic [CW-1:0]     count_q;
	logic              busy_q;

	logic [SIZE_W-1:0] n_c;
	logic [5:0]        nsq;
	logic [CW-1:0]     nn;
	logic [CW-1:0]     cnt_eff;
	logic [CW-1:0]     cnt_inc;
	logic              accept;
	logic              size_zero;
	logic              store_we;
	logic              last_elem;
	logic              err_req;
	logic [SAW-1:0]    raddr;
	logic [ELEM_WIDTH-1:0] rdata;
	uop_t              uop;
	logic              seq_active;
	logic              dp_fin;

	assign n_c       = (size_q > SIZE_W'(MAX_ORDER)) ? SIZE_W'(MAX_ORDER) : size_q;
	assign nsq       = 6'(n_c) * 6'(n_c);
	assign nn        = nsq[CW-1:0];
	assign accept    = start && !busy_q;
	assign size_zero = (size_q == '0);
	assign cnt_eff   = (count_q >= nn) ? '0 : count_q;
	assign cnt_inc   = cnt_eff + 1'b1;
	assign store_we  = accept && !size_zero;
	assign last_elem = store_we && (cnt_inc == nn);
	assign err_req   = accept && size_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_W'(1);
			count_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q  <= cfg_wdata;
				count_q <= '0;
			end else if (store_we) begin
				count_q <= last_elem ? '0 : cnt_inc;
			end
			if (last_elem) begin
				busy_q <= 1'b1;
			end else if (dp_fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	mdc_store #(
		.DEPTH(DEPTH),
		.SAW  (SAW),
		.EW   (ELEM_WIDTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(cnt_eff[SAW-1:0]),
		.wdata(element_value[ELEM_WIDTH-1:0]),
		.raddr(raddr),
		.rdata(rdata)
	);

	mdc_seq #(
		.SAW(SAW)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (last_elem),
		.n     (n_c),
		.uop   (uop),
		.raddr (raddr),
		.active(seq_active)
	);

	mdc_dp #(
		.EW(ELEM_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.uop        (uop),
		.rdata      (rdata),
		.n          (n_c),
		.err_req    (err_req),
		.fin        (dp_fin),
		.determinant(determinant),
		.saturated  (saturated),
		.size_error (size_error),
		.done       (done)
	);

	assign busy = busy_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(err_req || dp_fin))
		else $error("result strobe without a finished item");

	a_no_load_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		seq_active |-> !store_we)
		else $error("element write during expansion");

	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && size_error) |-> (determinant == '0 && !saturated))
		else $error("size error result not zero");

endmodule

FILE: rtl/core/mdc_store.sv
`timescale 1ns / 1ps
module mdc_store #(
	parameter int DEPTH = 16,
	parameter int SAW   = 4,
	parameter int EW    = 16
) (
	input  logic           clk,
	input  logic           we,
	input  logic [SAW-1:0] waddr,
	input  logic [EW-1:0]  wdata,
	input  logic [SAW-1:0] raddr,
	output logic [EW-1:0]  rdata
);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/mdc_seq.sv
`timescale 1ns / 1ps
module mdc_seq import mdc_pkg::*; #(
	parameter int SAW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [SIZE_W-1:0] n,
	output uop_t              uop,
	output logic [SAW-1:0]    raddr,
	output logic              active
);

	typedef enum logic [2:0] {ST_IDLE, ST_ONE, ST_L2, ST_GAP2, ST_L3, ST_GAP3, ST_L4} state_t;

	state_t     state_q;
	logic [2:0] grp_q;
	logic [1:0] sub_q;

	pair_t      pc;
	trio_t      oc;
	logic [1:0] r2;
	logic [1:0] r3;
	logic [3:0] full_addr;

	always_comb begin
		pc = pair_cols(grp_q);
		oc = other_cols(grp_q[1:0]);
		r2 = 2'(n - 3'd2);
		r3 = 2'(n - 3'd3);
		full_addr = '0;
		uop = '{op: OP_NOP, src: SRC_A, midx: '0, neg: 1'b0, last: 1'b0, dst: DST_M2,
			didx: '0};
		case (state_q)
			ST_ONE: begin
				uop.op   = OP_MAC;
				uop.src  = SRC_ONE;
				uop.last = 1'b1;
				uop.dst  = DST_FINAL;
			end
			ST_L2: begin
				case (sub_q)
					2'd0: begin
						uop.op    = OP_LDA;
						full_addr = elem_addr(r2, pc.a, n);
					end
					2'd1: begin
						uop.op    = OP_MAC;
						full_addr = elem_addr(r2 + 2'd1, pc.b, n);
					end
					2'd2: begin
						uop.op    = OP_LDA;
						full_addr = elem_addr(r2 + 2'd1, pc.a, n);
					end
					default: begin
						uop.op    = OP_MAC;
						uop.neg   = 1'b1;
						uop.last  = 1'b1;
						uop.dst   = (n == 3'd2) ? DST_FINAL : DST_M2;
						uop.didx  = grp_q;
						full_addr = elem_addr(r2, pc.b, n);
					end
				endcase
			end
			ST_L3: begin
				uop.op  = OP_MAC;
				uop.src = SRC_M2;
				case (sub_q)
					2'd0: begin
						uop.midx  = pair_idx(oc.b, oc.c);
						full_addr = elem_addr(r3, oc.a, n);
					end
					2'd1: begin
						uop.neg   = 1'b1;
						uop.midx  = pair_idx(oc.a, oc.c);
						full_addr = elem_addr(r3, oc.b, n);
					end
					default: begin
						uop.midx  = pair_idx(oc.a, oc.b);
						uop.last  = 1'b1;
						uop.dst   = (n == 3'd3) ? DST_FINAL : DST_M3;
						uop.didx  = grp_q;
						full_addr = elem_addr(r3, oc.c, n);
					end
				endcase
			end
			ST_L4: begin
				uop.op    = OP_MAC;
				uop.src   = SRC_M3;
				uop.midx  = grp_q;
				uop.neg   = grp_q[0];
				uop.last  = (grp_q == 3'd3);
				uop.dst   = DST_FINAL;
				full_addr = elem_addr(2'd0, grp_q[1:0], n);
			end
			default: begin
			end
		endcase
	end

	assign raddr  = full_addr[SAW-1:0];
	assign active = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grp_q   <= '0;
			sub_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						grp_q   <= '0;
						sub_q   <= '0;
						state_q <= (n == 3'd1) ? ST_ONE : ST_L2;
					end
				end
				ST_ONE: begin
					state_q <= ST_IDLE;
				end
				ST_L2: begin
					if (sub_q == 2'd3) begin
						sub_q <= '0;
						if (n == 3'd2) begin
							state_q <= ST_IDLE;
						end else if ((n == 3'd3 && grp_q == 3'd3) ||
								(n != 3'd3 && grp_q == 3'd5)) begin
							state_q <= ST_GAP2;
						end else if (n == 3'd3 && grp_q == 3'd1) begin
							grp_q <= 3'd3;
						end else begin
							grp_q <= grp_q + 3'd1;
						end
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				ST_GAP2: begin
					grp_q   <= (n == 3'd3) ? 3'd3 : 3'd0;
					sub_q   <= '0;
					state_q <= ST_L3;
				end
				ST_L3: begin
					if (sub_q == 2'd2) begin
						sub_q <= '0;
						if (n == 3'd3) begin
							state_q <= ST_IDLE;
						end else if (grp_q == 3'd3) begin
							state_q <= ST_GAP3;
						end else begin
							grp_q <= grp_q + 3'd1;
						end
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				ST_GAP3: begin
					grp_q   <= '0;
					state_q <= ST_L4;
				end
				ST_L4: begin
					if (grp_q == 3'd3) begin
						state_q <= ST_IDLE;
					end else begin
						grp_q <= grp_q + 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/mdc_dp.sv
`timescale 1ns / 1ps
module mdc_dp import mdc_pkg::*; #(
	parameter int EW = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  uop_t                    uop,
	input  logic [EW-1:0]           rdata,
	input  logic [SIZE_W-1:0]       n,
	input  logic                    err_req,
	output logic                    fin,
	output logic signed [OUT_W-1:0] determinant,
	output logic                    saturated,
	output logic                    size_error,
	output logic                    done
);

	localparam int W2 = 2 * EW + 1;
	localparam int W3 = 3 * EW + 3;
	localparam int PW = EW + W3;
	localparam int AW = 4 * EW + 4;
	localparam int XW = AW + OUT_FRAC - FRAC_BITS;
	localparam int SW = (XW > OUT_W + 1) ? XW : OUT_W + 1;

	uop_t                 uop_s1;
	uop_t                 uop_s2;
	logic signed [EW-1:0] opa_q;
	logic signed [W2-1:0] m2_q [NUM_M2];
	logic signed [W3-1:0] m3_q [NUM_M3];
	logic signed [W3-1:0] opnd;
	logic signed [EW-1:0] d;
	logic signed [PW-1:0] prod_c;
	logic signed [PW-1:0] prod_s2;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] acc_next;
	logic signed [AW-1:0] prod_ext;
	logic signed [AW-1:0] raw_s3;
	logic                 fin_s3;
	logic signed [SW-1:0] ext;
	logic signed [SW-1:0] sh;
	logic                 fits;
	logic signed [OUT_W-1:0] det_q;
	logic                 sat_q;
	logic                 err_q;
	logic                 done_q;

	assign d = rdata;

	always_comb begin
		case (uop_s1.src)
			SRC_A:   opnd = W3'(opa_q);
			SRC_M2:  opnd = W3'(m2_q[uop_s1.midx]);
			SRC_M3:  opnd = m3_q[uop_s1.midx[1:0]];
			default: opnd = W3'(1);
		endcase
	end

	assign prod_c   = d * opnd;
	assign prod_ext = AW'(prod_s2);
	assign acc_next = uop_s2.neg ? acc_q - prod_ext : acc_q + prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uop_s1 <= '{op: OP_NOP, src: SRC_A, midx: '0, neg: 1'b0, last: 1'b0,
				dst: DST_M2, didx: '0};
			uop_s2 <= '{op: OP_NOP, src: SRC_A, midx: '0, neg: 1'b0, last: 1'b0,
				dst: DST_M2, didx: '0};
			acc_q  <= '0;
			fin_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			uop_s1 <= uop;
			uop_s2 <= uop_s1;
			fin_s3 <= (uop_s2.op == OP_MAC) && uop_s2.last && (uop_s2.dst == DST_FINAL);
			if (uop_s2.op == OP_MAC) begin
				acc_q <= uop_s2.last ? '0 : acc_next;
			end
			done_q <= fin_s3 || err_req;
		end
	end

	always_ff @(posedge clk) begin
		if (uop_s1.op == OP_LDA) begin
			opa_q <= d;
		end
		prod_s2 <= prod_c;
		if (uop_s2.op == OP_MAC && uop_s2.last) begin
			case (uop_s2.dst)
				DST_M2:  m2_q[uop_s2.didx] <= acc_next[W2-1:0];
				DST_M3:  m3_q[uop_s2.didx[1:0]] <= acc_next[W3-1:0];
				default: raw_s3 <= acc_next;
			endcase
		end
	end

	always_comb begin
		ext = SW'(raw_s3);
		case (n)
			3'd1:    sh = ext <<< (OUT_FRAC - FRAC_BITS);
			3'd3:    sh = ext >>> (3 * FRAC_BITS - OUT_FRAC);
			3'd4:    sh = ext >>> (4 * FRAC_BITS - OUT_FRAC);
			default: sh = ext;
		endcase
		fits = (sh[SW-1:OUT_W-1] == {(SW - OUT_W + 1){sh[OUT_W-1]}});
	end

	always_ff @(posedge clk) begin
		if (err_req) begin
			det_q <= '0;
			sat_q <= 1'b0;
			err_q <= 1'b1;
		end else if (fin_s3) begin
			if (fits) begin
				det_q <= sh[OUT_W-1:0];
			end else begin
				det_q <= sh[SW-1] ? {1'b1, {(OUT_W - 1){1'b0}}} : {1'b0, {(OUT_W - 1){1'b1}}};
			end
			sat_q <= !fits;
			err_q <= 1'b0;
		end
	end

	assign fin         = fin_s3;
	assign determinant = det_q;
	assign saturated   = sat_q;
	assign size_error  = err_q;
	assign done        = done_q;

endmodule

FILE: verif/matrix_determinant_cofactor_test.sv
`timescale 1ns / 1ps
module matrix_determinant_cofactor_test;
	import mdc_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0] det;
		logic                    sat;
		logic                    err;
	} det_result_t;

	localparam int SETTLE_CYCLES = 64;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [15:0]      element_value;
	logic                    cfg_we;
	logic [SIZE_W-1:0]       cfg_wdata;
	logic signed [OUT_W-1:0] determinant;
	logic                    saturated;
	logic                    size_error;
	logic                    done;

	logic signed [15:0] pending_elements[$];
	det_result_t        expected_dets[$];
	logic signed [15:0] element_copy[16];
	int                 element_cnt;
	int                 order_reg;
	int                 gap_cnt;
	int                 error_cnt;
	bit                 idle_en;
	bit                 taken;

	matrix_determinant_cofactor i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.element_value(element_value),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.determinant(determinant),
		.saturated(saturated),
		.size_error(size_error),
		.done(done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic signed [127:0] elem_at(int r, int c, int n);
		logic signed [127:0] v;
		v = element_copy[(r * n + c) % 16];
		return v;
	endfunction

	function automatic logic signed [127:0] minor2_of(int r, int a, int b, int n);
		return elem_at(r, a, n) * elem_at(r + 1, b, n) - elem_at(r + 1, a, n) * elem_at(r, b, n);
	endfunction

	function automatic logic signed [127:0] minor3_of(int r, int a, int b, int c, int n);
		return elem_at(r, a, n) * minor2_of(r + 1, b, c, n)
			- elem_at(r, b, n) * minor2_of(r + 1, a, c, n)
			+ elem_at(r, c, n) * minor2_of(r + 1, a, b, n);
	endfunction

	function automatic det_result_t determinant_of(int n);
		det_result_t         res;
		logic signed [127:0] raw;
		logic signed [127:0] term;
		int                  cols[3];
		int                  k;
		if (n == 1) begin
			raw = elem_at(0, 0, n) * 256;
		end else if (n == 2) begin
			raw = minor2_of(0, 0, 1, n);
		end else if (n == 3) begin
			raw = minor3_of(0, 0, 1, 2, n);
		end else begin
			raw = 0;
			for (int j = 0; j < 4; j++) begin
				k = 0;
				for (int c = 0; c < 4; c++) begin
					if (c != j) begin
						cols[k] = c;
						k++;
					end
				end
				term = elem_at(0, j, n) * minor3_of(1, cols[0], cols[1], cols[2], n);
				raw = (j % 2 == 1) ? raw - term : raw + term;
			end
		end
		if (n >= 2)
			raw = raw >>> (FRAC_BITS * n - 16);
		res.err = 1'b0;
		if (raw > 128'sh7FFF_FFFF_FFFF_FFFF) begin
			res.det = {1'b0, {(OUT_W-1){1'b1}}};
			res.sat = 1'b1;
		end else if (raw < -128'sh8000_0000_0000_0000) begin
			res.det = {1'b1, {(OUT_W-1){1'b0}}};
			res.sat = 1'b1;
		end else begin
			res.det = raw[OUT_W-1:0];
			res.sat = 1'b0;
		end
		return res;
	endfunction

	task automatic accept_element(input logic signed [15:0] v);
		det_result_t res;
		int          n;
		n = order_reg;
		if (n == 0) begin
			res.det = '0;
			res.sat = 1'b0;
			res.err = 1'b1;
			expected_dets.push_back(res);
		end else begin
			if (n > 4)
				n = 4;
			if (element_cnt >= n * n)
				element_cnt = 0;
			element_copy[element_cnt] = v;
			element_cnt++;
			if (element_cnt == n * n) begin
				element_cnt = 0;
				expected_dets.push_back(determinant_of(n));
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		error_cnt++;
	endtask

	function automatic int random_gap();
		int r;
		if (!idle_en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [15:0] random_element();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(0, 1023)) - 512);
			3: return 16'sh0100;
			default: return 16'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		det_result_t want;
		if (start && !busy) begin
			accept_element(pending_elements.pop_front());
			taken <= 1'b1;
		end
		if (done) begin
			if (expected_dets.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = expected_dets.pop_front();
				if (determinant !== want.det)
					report_mismatch($sformatf("determinant %0d, want %0d", determinant, want.det));
				if (saturated !== want.sat)
					report_mismatch($sformatf("saturated %b, want %b", saturated, want.sat));
				if (size_error !== want.err)
					report_mismatch($sformatf("size_error %b, want %b", size_error, want.err));
			end
		end
	end

	// hold the item until taken, then idle or advance
	always @(negedge clk) begin
		if (arst_n && !(start && !taken)) begin
			if (start && taken)
				gap_cnt = random_gap();
			if (gap_cnt > 0) begin
				gap_cnt--;
				start <= 1'b0;
			end else if (pending_elements.size() > 0) begin
				start <= 1'b1;
				element_value <= pending_elements[0];
			end else begin
				start <= 1'b0;
			end
		end
		taken <= 1'b0;
	end

	task automatic drain();
		while (pending_elements.size() > 0 || start)
			@(negedge clk);
		while (expected_dets.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_size(input int value);
		drain();
		cfg_wdata <= SIZE_W'(value);
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		order_reg = value;
		element_cnt = 0;
	endtask

	task automatic queue_matrices(input int size, input int count);
		int n;
		n = (size == 0) ? 1 : (size > 4 ? 4 : size);
		repeat (count * n * n)
			pending_elements.push_back(random_element());
	endtask

	initial begin
		int sizes[$];
		int sz;
		arst_n = 1'b0;
		start = 1'b0;
		element_value = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		gap_cnt = 0;
		error_cnt = 0;
		element_cnt = 0;
		order_reg = 1;
		idle_en = 1'b0;
		taken = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		pending_elements.push_back(16'sh7FFF);
		pending_elements.push_back(16'sh8000);
		pending_elements.push_back(16'sh0000);
		write_size(2);
		pending_elements.push_back(16'sh8000);
		pending_elements.push_back(16'sh7FFF);
		pending_elements.push_back(16'sh7FFF);
		pending_elements.push_back(16'sh8000);
		write_size(4);
		repeat (16) pending_elements.push_back(16'sh8000);
		write_size(3);
		pending_elements.push_back(16'sh0100);
		pending_elements.push_back(16'sh0200);
		write_size(0);
		pending_elements.push_back(16'sh1234);
		pending_elements.push_back(16'shEDCB);
		write_size(7);
		repeat (16) pending_elements.push_back(16'sh7FFF);

		sizes = '{1, 2, 3, 4, 0, 4, 3, 5, 2, 4, 6, 1, 3, 4, 0, 2, 4, 3, 4, 1};
		foreach (sizes[i]) begin
			sz = sizes[i];
			write_size(sz);
			idle_en = (i % 4 != 2);
			queue_matrices(sz, (sz == 0 || sz == 1) ? 12 : (sz == 2 ? 6 : 2));
			if ($urandom_range(0, 3) == 0)
				pending_elements.push_back(random_element());
		end
		drain();
		if (error_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
